FILE: rtl/dpbd_pkg.sv
// Shared constants and types for the differential preamble burst detector.
package dpbd_pkg;

   localparam int BLOCK_LEN    = 8;
   localparam int NUM_BLOCKS   = 4;
   localparam int NUM_FRAMES   = 2;
   localparam int DATA_LEN     = 64;
   localparam int PREAMBLE_LEN = 32;
   localparam int LINE_DEPTH   = (DATA_LEN + PREAMBLE_LEN) * NUM_FRAMES * 2;
   localparam int FRAME_STRIDE = 2 * (BLOCK_LEN * NUM_BLOCKS + DATA_LEN);
   localparam int TAPS         = BLOCK_LEN * NUM_BLOCKS;
   localparam int LINE_W       = $clog2(LINE_DEPTH);
   localparam int PRE_W        = $clog2(PREAMBLE_LEN);
   localparam int J_W          = $clog2(BLOCK_LEN) > 0 ? $clog2(BLOCK_LEN) : 1;
   localparam int I_W          = $clog2(NUM_BLOCKS) > 0 ? $clog2(NUM_BLOCKS) : 1;
   localparam int K_W          = $clog2(NUM_FRAMES) > 0 ? $clog2(NUM_FRAMES) : 1;
   localparam int TAP_W        = $clog2(TAPS) > 0 ? $clog2(TAPS) : 1;
   localparam int CLR_W        = $clog2(LINE_DEPTH + 1);

   // Controller commands to the datapath.
   typedef struct packed {
      logic clear_wr;   // write zero at the clear address
      logic store;      // write the new sample, advance the write pointer
      logic load_coef;  // write a coefficient entry
      logic start;      // clear accumulators and totals
      logic tap_read;   // issue a memory read for the current tap
      logic tap_mac;    // accumulate the registered tap
      logic blk_step1;  // scale block sum, start chain products
      logic blk_step2;  // add chain products to total
      logic tot_step;   // scale and saturate total
      logic mag_step1;  // square components
      logic mag_step2;  // finish estimate
      logic [LINE_W-1:0] clr_addr;
      logic [K_W-1:0]    k;
      logic [I_W-1:0]    i;
      logic [J_W-1:0]    j;
   } dp_cmd_type;

endpackage

FILE: rtl/differential_preamble_burst_detector.sv
// Top level of the differential preamble burst detector.
//
// Request channel (req_valid/req_stall): command 0 pushes one complex sample
// and yields one response; command 1 loads one preamble coefficient and
// yields none. Response channel (rsp_valid/rsp_stall) carries detected and
// estimate. csr_write/csr_data set the detection threshold, reset 0.
// A sample request is worked through in order: the one shared complex
// multiplier takes the delay line taps one at a time through a single
// memory port, each tap first read and then accumulated, then two block
// steps per block, then the total is scaled, squared and compared. The next
// request can be taken in the same cycle that the response becomes valid.
// A coefficient load is written as it is accepted. Only one request is in
// work at a time. After reset all LINE_DEPTH (384) delay line entries are
// cleared, during which req_stall is high. A response holds while rsp_stall
// is high; the next sample is worked on meanwhile but waits before its result register.
module differential_preamble_burst_detector (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [15:0] req_sample_re,
   input  logic signed [15:0] req_sample_im,
   input  logic [4:0]         req_coef_index,
   input  logic signed [15:0] req_coef_re,
   input  logic signed [15:0] req_coef_im,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_detected,
   output logic [62:0]        rsp_estimate,
   input  logic               csr_write,
   input  logic [62:0]        csr_data
);
   import dpbd_pkg::*;

   dp_cmd_type  cmd;
   logic [62:0] threshold_ff;

   // Hold the threshold register.
   always_ff @(posedge clock) begin
      if (reset)
         threshold_ff <= '0;
      else if (csr_write)
         threshold_ff <= csr_data;
   end

   dpbd_control u_control (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_coef_index (req_coef_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd)
   );

   dpbd_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .sample_re  (req_sample_re),
      .sample_im  (req_sample_im),
      .coef_index (req_coef_index),
      .coef_re    (req_coef_re),
      .coef_im    (req_coef_im),
      .threshold  (threshold_ff),
      .reset      (reset),
      .detected   (rsp_detected),
      .estimate   (rsp_estimate)
   );

endmodule

FILE: rtl/dpbd_datapath.sv
// Datapath: delay line memory, coefficient table, shared multiplier and totals.
module dpbd_datapath (
   input  logic                 clock,
   input  dpbd_pkg::dp_cmd_type cmd,
   input  logic signed [15:0]   sample_re,
   input  logic signed [15:0]   sample_im,
   input  logic [4:0]           coef_index,
   input  logic signed [15:0]   coef_re,
   input  logic signed [15:0]   coef_im,
   input  logic [62:0]          threshold,
   input  logic                 reset,
   output logic                 detected,
   output logic [62:0]          estimate
);
   import dpbd_pkg::*;

   localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;

   logic [31:0]        line_mem [LINE_DEPTH];
   logic [31:0]        coef_mem [PREAMBLE_LEN];
   logic [LINE_W-1:0]  pos_ff, pos_in;
   logic [31:0]        tap_ff;
   logic [31:0]        pcoef_ff;
   logic signed [47:0] acc_re_ff, acc_im_ff;
   logic signed [23:0] prev_re_ff, prev_im_ff, b_re_ff, b_im_ff;
   logic signed [79:0] tot_re_ff, tot_im_ff;
   logic signed [47:0] c1_ff, c2_ff, c3_ff, c4_ff;
   logic signed [31:0] cur_re_ff, cur_im_ff, old_re_ff, old_im_ff;
   logic [63:0]        m_a_ff, m_b_ff, m_c_ff, m_d_ff;

   logic [LINE_W+2:0]  raddr_w;
   logic [LINE_W-1:0]  raddr;
   logic [PRE_W-1:0]   cidx;
   logic signed [16:0] neg_im;
   logic signed [15:0] st_im;
   logic signed [15:0] s_re, s_im, p_re, p_im;
   logic signed [47:0] bsh_re, bsh_im;
   logic signed [23:0] bs_re, bs_im;
   logic signed [79:0] tsh_re, tsh_im;
   logic signed [31:0] ts_re, ts_im;
   logic [63:0]        e1, e2, est;

   // Negate coefficient imaginary part with saturation.
   assign neg_im = -{coef_im[15], coef_im};
   assign st_im  = (neg_im > 17'sd32767) ? 16'sd32767 : neg_im[15:0];

   // Tap address: oldest at pos, offset by frame and tap.
   always_comb begin
      raddr_w = (LINE_W+3)'(pos_ff)
              + (LINE_W+3)'(int'(cmd.k) * FRAME_STRIDE)
              + (LINE_W+3)'(2 * (int'(cmd.i) * BLOCK_LEN + int'(cmd.j)));
      if (raddr_w >= (LINE_W+3)'(LINE_DEPTH))
         raddr_w = raddr_w - (LINE_W+3)'(LINE_DEPTH);
      if (raddr_w >= (LINE_W+3)'(LINE_DEPTH))
         raddr_w = raddr_w - (LINE_W+3)'(LINE_DEPTH);
      raddr = raddr_w[LINE_W-1:0];
      cidx  = PRE_W'((int'(cmd.i) * BLOCK_LEN + int'(cmd.j)) % PREAMBLE_LEN);
   end

   // Memory writes and registered reads.
   always_ff @(posedge clock) begin
      if (cmd.clear_wr)
         line_mem[cmd.clr_addr] <= '0;
      else if (cmd.store)
         line_mem[pos_ff] <= {sample_re, sample_im};
      if (cmd.load_coef)
         coef_mem[coef_index[PRE_W-1:0]] <= {coef_re, st_im};
      if (cmd.tap_read) begin
         tap_ff   <= line_mem[raddr];
         pcoef_ff <= coef_mem[cidx];
      end
   end

   // Write pointer.
   always_comb begin
      pos_in = pos_ff;
      if (cmd.store)
         pos_in = (pos_ff == LINE_W'(LINE_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         pos_ff <= '0;
      else
         pos_ff <= pos_in;
   end

   assign s_re = tap_ff[31:16];
   assign s_im = tap_ff[15:0];
   assign p_re = pcoef_ff[31:16];
   assign p_im = pcoef_ff[15:0];

   // Block sum scaling.
   assign bsh_re = acc_re_ff >>> 15;
   assign bsh_im = acc_im_ff >>> 15;
   assign bs_re = (bsh_re > 48'sd8388607) ? 24'sd8388607 :
                  (bsh_re < -48'sd8388608) ? -24'sd8388608 : bsh_re[23:0];
   assign bs_im = (bsh_im > 48'sd8388607) ? 24'sd8388607 :
                  (bsh_im < -48'sd8388608) ? -24'sd8388608 : bsh_im[23:0];

   // Total scaling.
   assign tsh_re = tot_re_ff >>> 16;
   assign tsh_im = tot_im_ff >>> 16;
   assign ts_re = (tsh_re > 80'sd2147483647) ? 32'sh7FFFFFFF :
                  (tsh_re < -80'sd2147483648) ? 32'sh80000000 : tsh_re[31:0];
   assign ts_im = (tsh_im > 80'sd2147483647) ? 32'sh7FFFFFFF :
                  (tsh_im < -80'sd2147483648) ? 32'sh80000000 : tsh_im[31:0];

   // Magnitudes and estimate.
   always_comb begin
      logic [64:0] s1, s2;
      s1  = {1'b0, m_a_ff} + {1'b0, m_b_ff};
      s2  = {1'b0, m_c_ff} + {1'b0, m_d_ff};
      e1  = (s1 > {1'b0, MAX63}) ? MAX63 : s1[63:0];
      e2  = (s2 > {1'b0, MAX63}) ? MAX63 : s2[63:0];
      est = (e1 >= e2) ? e1 : e2;
   end

   // Sequenced arithmetic: complex tap products are taken one at a time.
   always_ff @(posedge clock) begin
      if (reset) begin
         old_re_ff <= '0;
         old_im_ff <= '0;
      end else if (cmd.mag_step2) begin
         old_re_ff <= cur_re_ff;
         old_im_ff <= cur_im_ff;
      end
      if (cmd.start) begin
         acc_re_ff  <= '0;
         acc_im_ff  <= '0;
         prev_re_ff <= '0;
         prev_im_ff <= '0;
         tot_re_ff  <= '0;
         tot_im_ff  <= '0;
      end
      if (cmd.tap_mac) begin
         acc_re_ff <= acc_re_ff + p_re * s_re - p_im * s_im;
         acc_im_ff <= acc_im_ff + p_re * s_im + p_im * s_re;
      end
      if (cmd.blk_step1) begin
         b_re_ff <= bs_re;
         b_im_ff <= bs_im;
         c1_ff <= bs_re * prev_re_ff;
         c2_ff <= bs_im * prev_im_ff;
         c3_ff <= bs_im * prev_re_ff;
         c4_ff <= bs_re * prev_im_ff;
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end
      if (cmd.blk_step2) begin
         tot_re_ff  <= tot_re_ff + 80'(c1_ff) + 80'(c2_ff);
         tot_im_ff  <= tot_im_ff + 80'(c3_ff) - 80'(c4_ff);
         prev_re_ff <= b_re_ff;
         prev_im_ff <= b_im_ff;
      end
      if (cmd.tot_step) begin
         cur_re_ff <= ts_re;
         cur_im_ff <= ts_im;
      end
      if (cmd.mag_step1) begin
         m_a_ff <= cur_re_ff * cur_re_ff;
         m_b_ff <= cur_im_ff * cur_im_ff;
         m_c_ff <= old_re_ff * old_re_ff;
         m_d_ff <= old_im_ff * old_im_ff;
      end
      if (cmd.mag_step2) begin
         estimate <= est[62:0];
         detected <= est[62:0] > threshold;
      end
   end

endmodule

FILE: rtl/dpbd_control.sv
// Controller: clearing pass, tap sequencing and the result handshake.
module dpbd_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_command,
   input  logic [4:0]           req_coef_index,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dpbd_pkg::dp_cmd_type cmd
);
   import dpbd_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_MAC, ST_BLK1, ST_BLK2,
      ST_TOT, ST_MAG1, ST_MAG2, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [I_W-1:0]    i_ff, i_in;
   logic [J_W-1:0]    j_ff, j_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              last_j, last_i, last_k;

   assign req_stall = !(state_ff == ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign last_j = (j_ff == J_W'(BLOCK_LEN - 1));
   assign last_i = (i_ff == I_W'(NUM_BLOCKS - 1));
   assign last_k = (k_ff == K_W'(NUM_FRAMES - 1));

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.clr_addr = clr_ff[LINE_W-1:0];
      cmd.k        = k_ff;
      cmd.i        = i_ff;
      cmd.j        = j_ff;
      if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(LINE_DEPTH - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command) begin
                  cmd.load_coef = (32'(req_coef_index) < PREAMBLE_LEN);
               end else begin
                  cmd.store = 1'b1;
                  cmd.start = 1'b1;
                  k_in = '0;
                  i_in = '0;
                  j_in = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.tap_read = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.tap_mac = 1'b1;
            if (last_j) begin
               j_in = '0;
               state_in = ST_BLK1;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_BLK1: begin
            cmd.blk_step1 = 1'b1;
            state_in = ST_BLK2;
         end
         ST_BLK2: begin
            cmd.blk_step2 = 1'b1;
            state_in = ST_READ;
            if (last_i) begin
               i_in = '0;
               if (last_k)
                  state_in = ST_TOT;
               else
                  k_in = k_ff + 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_TOT: begin
            cmd.tot_step = 1'b1;
            state_in = ST_MAG1;
         end
         ST_MAG1: begin
            cmd.mag_step1 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait until the previous result has left
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_MAG2;
            end
         end
         ST_MAG2: begin
            cmd.mag_step2 = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state, counters and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAG2) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten");
   // Requests are taken only when idle.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == ST_IDLE))
      else $error("request taken while busy");
   // A sample request starts the tap sequence.
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_command) |=> (state_ff == ST_READ))
      else $error("sample did not start sequence");

endmodule

FILE: test/differential_preamble_burst_detector_tb.sv
// Testbench for the differential preamble burst detector: scoreboard with predictor, drivers.
module differential_preamble_burst_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dpbd_pkg::*;

   localparam bit          CMD_SAMPLE = 1'b0;
   localparam bit          CMD_LOAD   = 1'b1;
   localparam bit [62:0]   EST_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam int          IDLE_LIMIT = 4000;
   localparam int          SETTLE     = 120;

   typedef struct {
      bit        detected;
      bit [62:0] estimate;
   } detect_result_type;

   // Predicts detector responses and checks them in order.
   class detect_scoreboard;
      int                 line_re [LINE_DEPTH];
      int                 line_im [LINE_DEPTH];
      int                 line_pos;
      int                 conj_re [PREAMBLE_LEN];
      int                 conj_im [PREAMBLE_LEN];
      longint             last_re;
      longint             last_im;
      bit [62:0]          threshold;
      detect_result_type  pending_results[$];
      int                 errors;

      function new();
         foreach (line_re[n]) begin
            line_re[n] = 0;
            line_im[n] = 0;
         end
         foreach (conj_re[n]) begin
            conj_re[n] = 0;
            conj_im[n] = 0;
         end
         line_pos  = 0;
         last_re   = 0;
         last_im   = 0;
         threshold = '0;
         errors    = 0;
      endfunction

      function longint clamp(longint v, int bits);
         longint hi;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      function bit [62:0] power(longint re, longint im);
         bit [63:0] s;
         s = 64'(re * re) + 64'(im * im);
         return (s > {1'b0, EST_MAX}) ? EST_MAX : s[62:0];
      endfunction

      function void note_request(bit cmd, int sre, int sim, int idx, int cre, int cim);
         longint            tot_re, tot_im, prv_re, prv_im, acc_re, acc_im, b_re, b_im;
         longint            cur_re, cur_im;
         int                base, t, a, p;
         bit [62:0]         e_now, e_last;
         detect_result_type r;
         // load: keep the conjugated point, saturating the negation
         if (cmd == CMD_LOAD) begin
            if (idx < PREAMBLE_LEN) begin
               conj_re[idx] = cre;
               conj_im[idx] = (cim == -32768) ? 32767 : -cim;
            end
            return;
         end
         // push the sample over the oldest entry
         line_re[line_pos] = sre;
         line_im[line_pos] = sim;
         line_pos = (line_pos + 1) % LINE_DEPTH;
         tot_re = 0; tot_im = 0; prv_re = 0; prv_im = 0;
         for (int k = 0; k < NUM_FRAMES; k++) begin
            base = k * FRAME_STRIDE;
            for (int i = 0; i < NUM_BLOCKS; i++) begin
               acc_re = 0;
               acc_im = 0;
               for (int j = 0; j < BLOCK_LEN; j++) begin
                  t = base + 2 * (i * BLOCK_LEN + j);
                  a = (line_pos + t) % LINE_DEPTH;
                  p = (i * BLOCK_LEN + j) % PREAMBLE_LEN;
                  acc_re += longint'(conj_re[p]) * line_re[a]
                          - longint'(conj_im[p]) * line_im[a];
                  acc_im += longint'(conj_re[p]) * line_im[a]
                          + longint'(conj_im[p]) * line_re[a];
               end
               b_re = clamp(acc_re >>> 15, 24);
               b_im = clamp(acc_im >>> 15, 24);
               tot_re += b_re * prv_re + b_im * prv_im;
               tot_im += b_im * prv_re - b_re * prv_im;
               prv_re = b_re;
               prv_im = b_im;
            end
         end
         cur_re = clamp(tot_re >>> 16, 32);
         cur_im = clamp(tot_im >>> 16, 32);
         e_now  = power(cur_re, cur_im);
         e_last = power(last_re, last_im);
         last_re = cur_re;
         last_im = cur_im;
         r.estimate = (e_now >= e_last) ? e_now : e_last;
         r.detected = r.estimate > threshold;
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_response(bit det, bit [62:0] est);
         detect_result_type r;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response detected=%0b estimate=%0d", $time, det, est);
            errors++;
            return;
         end
         r = pending_results.pop_front();
         if (det !== r.detected) begin
            $display("%0t: detected mismatch, expected %0b actual %0b",
                     $time, r.detected, det);
            errors++;
         end
         if (est !== r.estimate) begin
            $display("%0t: estimate mismatch, expected %0d actual %0d",
                     $time, r.estimate, est);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_SAMPLE;
   logic signed [15:0] req_sample_re = '0;
   logic signed [15:0] req_sample_im = '0;
   logic [4:0]         req_coef_index = '0;
   logic signed [15:0] req_coef_re = '0;
   logic signed [15:0] req_coef_im = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_detected;
   logic [62:0]        rsp_estimate;
   logic               csr_write = 1'b0;
   logic [62:0]        csr_data = '0;

   detect_scoreboard sb = new();
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               stall_mode = 0;
   int               stall_count = 0;
   int               preamble_re [PREAMBLE_LEN];
   int               preamble_im [PREAMBLE_LEN];

   differential_preamble_burst_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_sample_re  (req_sample_re),
      .req_sample_im  (req_sample_im),
      .req_coef_index (req_coef_index),
      .req_coef_re    (req_coef_re),
      .req_coef_im    (req_coef_im),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_detected   (rsp_detected),
      .rsp_estimate   (rsp_estimate),
      .csr_write      (csr_write),
      .csr_data       (csr_data)
   );

   always #2 clock = ~clock;

   // Check responses and watch for a hang.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_detected, rsp_estimate);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("differential_preamble_burst_detector_tb: errors");
         $finish;
      end
   end

   // Stall the response side on one of four patterns, chosen at random by stall_count.
   always @(negedge clock) begin
      stall_count <= stall_count + 1;
      if (stall_count % 64 == 0) begin
         stall_mode <= $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= ((stall_count / 16) % 2 == 1);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   function automatic int edge16();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return $signed(16'($urandom));
      endcase
   endfunction

   // Drive one request, hold until accepted, then pace the sender.
   task automatic send_request(bit cmd, int sre, int sim, int idx, int cre, int cim);
      int gap;
      // wrap every field to its port width so the prediction sees the driven bits
      sre = $signed(16'(sre));
      sim = $signed(16'(sim));
      idx = int'(5'(idx));
      cre = $signed(16'(cre));
      cim = $signed(16'(cim));
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_sample_re  <= 16'(sre);
      req_sample_im  <= 16'(sim);
      req_coef_index <= 5'(idx);
      req_coef_re    <= 16'(cre);
      req_coef_im    <= 16'(cim);
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, sre, sim, idx, cre, cim);
      if (cmd == CMD_LOAD) begin
         preamble_re[idx] = cre;
         preamble_im[idx] = cim;
      end
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(0, 20);
      end
   endtask

   task automatic send_sample(int sre, int sim);
      send_request(CMD_SAMPLE, sre, sim, $urandom_range(0, 31), edge16(), edge16());
   endtask

   task automatic send_load(int idx, int cre, int cim);
      send_request(CMD_LOAD, edge16(), edge16(), idx, cre, cim);
   endtask

   // Drain all responses, let the engine settle, then write the threshold.
   task automatic write_threshold(bit [62:0] value);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.threshold = value;
   endtask

   // Send one preamble burst over all frames with random data between frames.
   task automatic send_burst(int noise);
      int p;
      for (int k = 0; k < NUM_FRAMES; k++) begin
         for (int s = 0; s < 2 * TAPS; s++) begin
            p = s / 2;
            send_sample(preamble_re[p] + $urandom_range(0, 2 * noise) - noise,
                        preamble_im[p] + $urandom_range(0, 2 * noise) - noise);
         end
         if (k < NUM_FRAMES - 1) begin
            for (int s = 0; s < 2 * DATA_LEN; s++) send_sample(edge16(), edge16());
         end
      end
   endtask

   initial begin
      bit [62:0] level;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole table first, extremes and saturated negation included.
      for (int n = 0; n < PREAMBLE_LEN; n++) begin
         case (n)
            0: send_load(n, -32768, -32768);
            1: send_load(n, 32767, 32767);
            2: send_load(n, 0, 0);
            3: send_load(n, -32768, 32767);
            default: send_load(n, edge16(), edge16());
         endcase
      end
      send_sample(32767, 32767);
      send_sample(-32768, -32768);
      send_sample(0, 0);
      send_sample(-32768, 32767);
      send_sample(32767, -32768);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: level = '0;
            1: level = EST_MAX;
            2: level = 63'({$urandom, $urandom});
            default: level = 63'(1) << $urandom_range(20, 60);
         endcase
         write_threshold(level);
         for (int n = 0; n < 20; n++) begin
            if (phase % 2 == 1 && n < 8) send_load(n, 32767, -32768);
            else send_load($urandom_range(0, PREAMBLE_LEN - 1), edge16(), edge16());
         end
         send_burst(phase == 0 ? 0 : 1 << (4 * phase));
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 3) == 0) begin
               send_load($urandom_range(0, PREAMBLE_LEN - 1), edge16(), edge16());
            end else begin
               send_sample(edge16(), edge16());
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("differential_preamble_burst_detector_tb: clean");
      end else begin
         $display("differential_preamble_burst_detector_tb: errors");
      end
      $finish;
   end
endmodule
